// ===== design/pps_pkg.sv =====
package pps_pkg;

  localparam int SLOT_FIELD_W = 4;
  localparam int TIME_FIELD_W = 16;
  localparam int BURST_W      = 16;
  localparam int PRIO_W       = 8;
  localparam int COUNT_W      = 5;

  localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 5'd1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_FIELD_W-1:0] arrival;
    logic [BURST_W-1:0]      burst;
    logic [PRIO_W-1:0]       prio;
  } in_item_t;

  typedef struct packed {
    logic [TIME_FIELD_W-1:0] tick_time;
    logic [SLOT_FIELD_W-1:0] running;
    logic                    idle;
    logic                    new_segment;
    logic                    finished;
    logic                    all_done;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB
  } state_t;

endpackage

// ===== design/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler, one slot examined per cycle by a shared comparator.
// Load transaction: written straight into the task RAM, no result.
// Tick transaction: the slot scan reads the counted slots through the task RAM read port,
//   then the write-back state registers the result; the next transaction is accepted back in idle.
// Reset (rst_n low, synchronous): clears valid/done flags, clock, last choice, sets
//   task_count to 1; task RAM contents stay undefined, no clearing pass.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pps_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pps_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pps_pkg::COUNT_W-1:0]   cfg_data
);

  import pps_pkg::*;

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int REM_W  = BURST_W;
  localparam int ENT_W  = TIME_BITS + PRIO_W + REM_W;

  // control state
  state_t               state_r, state_nxt;
  logic [MAX_TASKS-1:0] done_r, done_nxt;
  logic [MAX_TASKS-1:0] loaded_r, loaded_nxt;
  logic [TIME_BITS-1:0] cur_time_r, cur_time_nxt;
  logic                 last_have_r, last_have_nxt;
  logic [SLOT_W-1:0]    last_slot_r, last_slot_nxt;
  logic [COUNT_W-1:0]   task_count_r, task_count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // scan state
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 cand_v_r, cand_v_nxt;
  logic [SLOT_W-1:0]    cand_slot_r, cand_slot_nxt;
  logic                 have_r, have_nxt;
  logic [1:0]           nd_r, nd_nxt;
  logic [SLOT_W-1:0]    best_slot_r, best_slot_nxt;
  logic [TIME_BITS-1:0] best_arr_r, best_arr_nxt;
  logic [PRIO_W-1:0]    best_prio_r, best_prio_nxt;
  logic [REM_W-1:0]     best_rem_r, best_rem_nxt;

  // task RAM: {arrival, priority, remaining}
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [ENT_W-1:0]     ram_rdata;

  logic [TIME_BITS-1:0] rd_arr;
  logic [PRIO_W-1:0]    rd_prio;
  logic [REM_W-1:0]     rd_rem;
  logic                 cand_arrived;
  logic                 cand_better;

  logic [CNT_W-1:0]                count_n;
  logic [SLOT_W+SLOT_FIELD_W-1:0]  slot_wide;
  logic [SLOT_W-1:0]               load_addr;
  logic                            load_ok;
  logic [TIME_BITS+TIME_FIELD_W-1:0] arr_wide;
  logic [TIME_BITS+TIME_FIELD_W-1:0] time_wide;
  logic [SLOT_W+SLOT_FIELD_W-1:0]  run_wide;
  logic [REM_W-1:0]                new_rem;
  logic                            fin;
  logic                            cand_done;

  pps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // a slot never loaded reads remaining zero
  assign rd_arr  = ram_rdata[ENT_W-1 -: TIME_BITS];
  assign rd_prio = ram_rdata[REM_W +: PRIO_W];
  assign rd_rem  = loaded_r[cand_slot_r] ? ram_rdata[REM_W-1:0] : '0;

  pps_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .cur_time  (cur_time_r),
    .cand_arr  (rd_arr),
    .cand_prio (rd_prio),
    .cand_rem  (rd_rem),
    .best_arr  (best_arr_r),
    .best_prio (best_prio_r),
    .best_rem  (best_rem_r),
    .arrived   (cand_arrived),
    .better    (cand_better)
  );

  // clamp the count register to the table size
  assign count_n = (32'(task_count_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                    : CNT_W'(task_count_r);

  assign slot_wide = (SLOT_W + SLOT_FIELD_W)'(in_data.slot);
  assign load_addr = slot_wide[SLOT_W-1:0];
  assign load_ok   = 32'(in_data.slot) < MAX_TASKS;
  assign arr_wide  = (TIME_BITS + TIME_FIELD_W)'(in_data.arrival);
  assign time_wide = (TIME_BITS + TIME_FIELD_W)'(cur_time_r);
  assign run_wide  = (SLOT_W + SLOT_FIELD_W)'(best_slot_r);

  // run the chosen task one unit; a zero count stays zero
  assign new_rem   = best_rem_r - REM_W'(best_rem_r != '0);
  assign fin       = have_r && (new_rem == '0);
  assign cand_done = done_r[cand_slot_r];

  // the block works on one transaction at a time; results sit in the output register
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      done_r       <= '0;
      loaded_r     <= '0;
      cur_time_r   <= '0;
      last_have_r  <= 1'b0;
      task_count_r <= TASK_COUNT_RESET;
      out_valid_r  <= 1'b0;
      issue_r      <= '0;
      cand_v_r     <= 1'b0;
      have_r       <= 1'b0;
      nd_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      done_r       <= done_nxt;
      loaded_r     <= loaded_nxt;
      cur_time_r   <= cur_time_nxt;
      last_have_r  <= last_have_nxt;
      task_count_r <= task_count_nxt;
      out_valid_r  <= out_valid_nxt;
      issue_r      <= issue_nxt;
      cand_v_r     <= cand_v_nxt;
      have_r       <= have_nxt;
      nd_r         <= nd_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    last_slot_r <= last_slot_nxt;
    out_data_r  <= out_data_nxt;
    cand_slot_r <= cand_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_arr_r  <= best_arr_nxt;
    best_prio_r <= best_prio_nxt;
    best_rem_r  <= best_rem_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    done_nxt       = done_r;
    loaded_nxt     = loaded_r;
    cur_time_nxt   = cur_time_r;
    last_have_nxt  = last_have_r;
    last_slot_nxt  = last_slot_r;
    task_count_nxt = task_count_r;
    out_data_nxt   = out_data_r;
    issue_nxt      = issue_r;
    cand_v_nxt     = cand_v_r;
    cand_slot_nxt  = cand_slot_r;
    have_nxt       = have_r;
    nd_nxt         = nd_r;
    best_slot_nxt  = best_slot_r;
    best_arr_nxt   = best_arr_r;
    best_prio_nxt  = best_prio_r;
    best_rem_nxt   = best_rem_r;
    ram_we         = 1'b0;
    ram_waddr      = best_slot_r;
    ram_wdata      = {best_arr_r, best_prio_r, new_rem};
    ram_re         = 1'b0;

    // drop the held result once the consumer takes it
    out_valid_nxt  = out_valid_r && out_stall;

    if (cfg_valid) begin
      task_count_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_TICK) begin
            // start a fresh scan from slot zero
            issue_nxt  = '0;
            cand_v_nxt = 1'b0;
            have_nxt   = 1'b0;
            nd_nxt     = '0;
            state_nxt  = S_SCAN;
          end else if (load_ok) begin
            // load: write the whole entry, mark pending unless burst is zero
            ram_we                = 1'b1;
            ram_waddr             = load_addr;
            ram_wdata             = {arr_wide[TIME_BITS-1:0], in_data.prio, in_data.burst};
            loaded_nxt[load_addr] = 1'b1;
            done_nxt[load_addr]   = (in_data.burst == '0);
          end
        end
      end

      S_SCAN: begin
        // evaluate the entry read last cycle
        if (cand_v_r && !cand_done) begin
          if (nd_r != 2'd2) begin
            nd_nxt = nd_r + 2'd1;
          end
          if (cand_arrived && (!have_r || cand_better)) begin
            have_nxt      = 1'b1;
            best_slot_nxt = cand_slot_r;
            best_arr_nxt  = rd_arr;
            best_prio_nxt = rd_prio;
            best_rem_nxt  = rd_rem;
          end
        end
        // issue the next read, or close the scan
        if (issue_r < count_n) begin
          ram_re        = 1'b1;
          cand_v_nxt    = 1'b1;
          cand_slot_nxt = issue_r[SLOT_W-1:0];
          issue_nxt     = issue_r + CNT_W'(1);
        end else begin
          cand_v_nxt = 1'b0;
          state_nxt  = S_WB;
        end
      end

      S_WB: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          if (have_r) begin
            ram_we = 1'b1;
            if (fin) begin
              done_nxt[best_slot_r] = 1'b1;
            end
          end
          out_valid_nxt            = 1'b1;
          out_data_nxt.tick_time   = time_wide[TIME_FIELD_W-1:0];
          out_data_nxt.running     = have_r ? run_wide[SLOT_FIELD_W-1:0] : '0;
          out_data_nxt.idle        = !have_r;
          out_data_nxt.new_segment = (have_r != last_have_r) ||
                                     (have_r && (best_slot_r != last_slot_r));
          out_data_nxt.finished    = fin;
          // all done: nothing pending, or the only pending slot just finished
          out_data_nxt.all_done    = (nd_r == 2'd0) || ((nd_r == 2'd1) && fin);
          last_have_nxt            = have_r;
          last_slot_nxt            = best_slot_r;
          cur_time_nxt             = cur_time_r + TIME_BITS'(1);
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pps_ram.sv =====
module pps_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pps_cmp.sv =====
module pps_cmp #(
  parameter int TIME_BITS = 16
) (
  input  logic [TIME_BITS-1:0]        cur_time,
  input  logic [TIME_BITS-1:0]        cand_arr,
  input  logic [pps_pkg::PRIO_W-1:0]  cand_prio,
  input  logic [pps_pkg::BURST_W-1:0] cand_rem,
  input  logic [TIME_BITS-1:0]        best_arr,
  input  logic [pps_pkg::PRIO_W-1:0]  best_prio,
  input  logic [pps_pkg::BURST_W-1:0] best_rem,
  output logic                        arrived,
  output logic                        better
);

  import pps_pkg::*;

  // priority first, then remaining time, then arrival: one lexicographic compare
  assign better  = {cand_prio, cand_rem, cand_arr} < {best_prio, best_rem, best_arr};
  assign arrived = cand_arr <= cur_time;

endmodule

// ===== tb/sv/preemptive_priority_scheduler_test.sv =====
module preemptive_priority_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SLOT_COUNT    = 16;
  // Leave room for the longest tick's scan and for the result to drain out.
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT   = 8_000_000;
  localparam int          RANDOM_ITEMS  = 2000;
  localparam logic [4:0]  NO_PICK       = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data = '0;

  // Task table as the scheduler should hold it.
  logic [TIME_FIELD_W-1:0] slot_arrival [SLOT_COUNT];
  logic [BURST_W-1:0]      slot_left    [SLOT_COUNT];
  logic [PRIO_W-1:0]       slot_prio    [SLOT_COUNT];
  logic                    slot_done    [SLOT_COUNT];
  logic [TIME_FIELD_W-1:0] sched_time = '0;
  logic [4:0]              prev_pick = NO_PICK;
  logic [COUNT_W-1:0]      task_count_q = TASK_COUNT_RESET;

  in_item_t  pending_q[$];
  out_item_t tick_result_q[$];

  int mismatch_count = 0;
  int cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  preemptive_priority_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Preference among two eligible slots: priority, then remaining time,
  // then arrival. Equal on all three keeps the lower slot already held.
  function automatic bit outranks(input int a, input int b);
    if (slot_prio[a] != slot_prio[b]) return slot_prio[a] < slot_prio[b];
    if (slot_left[a] != slot_left[b]) return slot_left[a] < slot_left[b];
    return slot_arrival[a] < slot_arrival[b];
  endfunction

  // One scheduler tick: pick, run one unit, advance the clock.
  function automatic out_item_t schedule_tick();
    out_item_t  res;
    int         span;
    logic [4:0] pick;
    bit         found;
    bit         fin;
    bit         all_fin;
    span = (task_count_q > SLOT_COUNT) ? SLOT_COUNT : int'(task_count_q);
    pick = NO_PICK;
    found = 1'b0;
    fin = 1'b0;
    for (int i = 0; i < span; i++) begin
      if (!slot_done[i] && slot_arrival[i] <= sched_time) begin
        if (!found || outranks(i, int'(pick))) begin
          pick = 5'(i);
          found = 1'b1;
        end
      end
    end
    if (found) begin
      if (slot_left[pick] != '0) slot_left[pick]--;
      if (slot_left[pick] == '0) begin
        slot_done[pick] = 1'b1;
        fin = 1'b1;
      end
    end
    all_fin = 1'b1;
    for (int i = 0; i < span; i++)
      if (!slot_done[i]) all_fin = 1'b0;
    res.tick_time   = sched_time;
    res.running     = found ? pick[SLOT_FIELD_W-1:0] : '0;
    res.idle        = !found;
    res.new_segment = (pick != prev_pick);
    res.finished    = fin;
    res.all_done    = all_fin;
    prev_pick = pick;
    sched_time = sched_time + 1'b1;
    return res;
  endfunction

  // Driver: take items from the pending queue in bursts with random gaps.
  // Hold the payload while stalled; update the table on each accepted load
  // and queue the expected result of each accepted tick.
  always @(posedge clk) begin
    bit accepted;
    accepted = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (accepted) begin
        if (in_data.cmd == CMD_TICK) begin
          tick_result_q.push_back(schedule_tick());
        end else begin
          slot_arrival[in_data.slot] = in_data.arrival;
          slot_left[in_data.slot]    = in_data.burst;
          slot_prio[in_data.slot]    = in_data.prio;
          slot_done[in_data.slot]    = (in_data.burst == '0);
        end
      end
      if (!in_valid || accepted) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // Start a new burst: mostly short ones, now and then a long run with no gaps.
            if ($urandom_range(0, 7) == 0) begin
              burst_left <= $urandom_range(64, 256);
              gap_left <= 0;
            end else begin
              burst_left <= $urandom_range(1, 16);
              gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation,
  // and drive the receiver's stall pattern.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_result_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", out_data));
      end else begin
        want = tick_result_q.pop_front();
        if (out_data.tick_time !== want.tick_time)
          report_mismatch($sformatf("tick_time got %0d want %0d",
                                    out_data.tick_time, want.tick_time));
        if (out_data.running !== want.running)
          report_mismatch($sformatf("t=%0d running got %0d want %0d",
                                    want.tick_time, out_data.running, want.running));
        if (out_data.idle !== want.idle)
          report_mismatch($sformatf("t=%0d idle got %b want %b",
                                    want.tick_time, out_data.idle, want.idle));
        if (out_data.new_segment !== want.new_segment)
          report_mismatch($sformatf("t=%0d new_segment got %b want %b",
                                    want.tick_time, out_data.new_segment, want.new_segment));
        if (out_data.finished !== want.finished)
          report_mismatch($sformatf("t=%0d finished got %b want %b",
                                    want.tick_time, out_data.finished, want.finished));
        if (out_data.all_done !== want.all_done)
          report_mismatch($sformatf("t=%0d all_done got %b want %b",
                                    want.tick_time, out_data.all_done, want.all_done));
      end
    end
    // Switch stall pattern when the mode counter runs out: none, coin flip, periodic, heavy.
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_stall <= (cycle_count % 3 == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  function automatic in_item_t load_item(input int slot, input logic [15:0] arr,
                                         input logic [15:0] burst, input logic [7:0] prio);
    in_item_t it;
    it.cmd     = CMD_LOAD;
    it.slot    = SLOT_FIELD_W'(slot);
    it.arrival = arr;
    it.burst   = burst;
    it.prio    = prio;
    return it;
  endfunction

  // Tick with random filler in the fields the block ignores.
  function automatic in_item_t tick_item();
    in_item_t it;
    it.cmd     = CMD_TICK;
    it.slot    = SLOT_FIELD_W'($urandom);
    it.arrival = TIME_FIELD_W'($urandom);
    it.burst   = BURST_W'($urandom);
    it.prio    = PRIO_W'($urandom);
    return it;
  endfunction

  // Random task near the expected clock: mostly short bursts and few priority
  // levels so ties and preemption happen often.
  function automatic in_item_t random_load(input int slot, input logic [15:0] est);
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    int          r;
    r = $urandom_range(0, 15);
    if (r < 2) arr = 16'($urandom);
    else if (r < 4) arr = est - 16'($urandom_range(0, 8));
    else arr = est + 16'($urandom_range(0, 24));
    r = $urandom_range(0, 31);
    if (r == 0) burst = 16'd0;
    else if (r == 1) burst = 16'hFFFF;
    else if (r < 4) burst = 16'($urandom);
    else burst = 16'($urandom_range(1, 8));
    prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    return load_item(slot, arr, burst, prio);
  endfunction

  // Wait until every transaction is taken and every result checked, then let
  // the block finish any scan still running.
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || tick_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_task_count(input logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    task_count_q = value;
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) pending_q.push_back(tick_item());
  endtask

  // One random phase: pick a slot count, load every counted slot, then mostly
  // ticks with fresh loads mixed in to force preemption.
  task automatic queue_random_phase(input int n_items);
    logic [COUNT_W-1:0] count_val;
    logic [15:0]        est;
    int                 span;
    int                 queued;
    int                 r;
    r = $urandom_range(0, 9);
    case (r)
      0: count_val = 5'd0;
      1: count_val = 5'($urandom_range(17, 31));
      2: count_val = 5'd16;
      3: count_val = 5'd1;
      default: count_val = 5'($urandom_range(1, 16));
    endcase
    wait_quiet();
    write_task_count(count_val);
    span = (count_val > SLOT_COUNT) ? SLOT_COUNT : int'(count_val);
    est = sched_time;
    queued = 0;
    for (int s = 0; s < span; s++) begin
      pending_q.push_back(random_load(s, est));
      queued++;
    end
    while (queued < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        pending_q.push_back(random_load($urandom_range(0, SLOT_COUNT - 1), est));
      end else begin
        pending_q.push_back(tick_item());
        est++;
      end
      queued++;
    end
  endtask

  initial begin
    int total;
    int n;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_left[i] = '0;
      slot_done[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Load every slot first so no tick ever reads an unwritten entry.
    pending_q.push_back(load_item(0, 16'd1, 16'd2, 8'd5));
    pending_q.push_back(load_item(1, 16'd0, 16'd3, 8'd2));
    pending_q.push_back(load_item(2, 16'd0, 16'd3, 8'd2));  // full tie with slot 1
    pending_q.push_back(load_item(3, 16'd2, 16'd1, 8'd0));
    pending_q.push_back(load_item(4, 16'd0, 16'd4, 8'd1));
    pending_q.push_back(load_item(5, 16'd0, 16'd0, 8'd0));  // zero burst, done at once
    pending_q.push_back(load_item(6, 16'd3, 16'd2, 8'd1));
    pending_q.push_back(load_item(7, 16'd1, 16'd2, 8'd1));  // earlier arrival than slot 6
    for (int s = 8; s < SLOT_COUNT - 1; s++)
      pending_q.push_back(load_item(s, 16'(s * 3), 16'(s), 8'(100 + s)));
    pending_q.push_back(load_item(15, 16'hFFFF, 16'hFFFF, 8'hFF));
    // Reset count of one: idle before arrival, run slot 0 to the end, idle again.
    queue_ticks(4);
    wait_quiet();
    write_task_count(5'd16);
    queue_ticks(4);
    wait_quiet();
    write_task_count(5'd0);  // no slot counted: idle with all_done
    queue_ticks(2);
    wait_quiet();
    write_task_count(5'd31);  // above the table size, acts as full
    queue_ticks(2);

    // Late arrivals near the top of the clock keep waiting while early ones run.
    wait_quiet();
    write_task_count(5'd4);
    pending_q.push_back(load_item(0, 16'd65533, 16'd6, 8'd1));
    pending_q.push_back(load_item(1, 16'd2, 16'd5, 8'd0));
    pending_q.push_back(load_item(2, 16'd65535, 16'd2, 8'd0));
    pending_q.push_back(load_item(3, 16'd0, 16'd0, 8'd0));
    queue_ticks(16);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      n = $urandom_range(30, 120);
      queue_random_phase(n);
      total += n;
    end

    wait_quiet();
    if (tick_result_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", tick_result_q.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pps_pkg.sv
design/pps_ram.sv
design/pps_cmp.sv
design/preemptive_priority_scheduler.sv
tb/sv/preemptive_priority_scheduler_test.sv
